// ===== sv/mwbd_pkg.sv =====
// Shared types, constants and helpers for the majority window button debouncer.
// No dependencies; the cell, tally, top level and testbench import this package.
`default_nettype none

package mwbd_pkg;

  localparam int WINDOW = 100;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int THR_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THR = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0] PRESS_THR_RST   = THR_W'(70);
  localparam logic [THR_W-1:0] RELEASE_THR_RST = THR_W'(30);

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_CENTER = 2'd1,
    CLS_LEFT   = 2'd2,
    CLS_RIGHT  = 2'd3
  } cls_t;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic step;
    cls_t cls_new;
    cls_t cls_old;
  } step_t;

  typedef struct packed {
    logic [THR_W-1:0] press_thr;
    logic [THR_W-1:0] rel_thr;
  } thr_t;

  function automatic cls_t classify(input logic left_pin, input logic right_pin);
    cls_t c;
    if (left_pin && right_pin) begin
      c = CLS_CENTER;
    end else if (left_pin) begin
      c = CLS_LEFT;
    end else if (right_pin) begin
      c = CLS_RIGHT;
    end else begin
      c = CLS_NONE;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mwbd_in_if.sv =====
// Input channel: valid/ready handshake carrying the two sampled pin levels.
// No dependencies.
`default_nettype none

interface mwbd_in_if;
  logic valid;
  logic ready;
  logic left_pin;
  logic right_pin;

  modport source (output valid, output left_pin, output right_pin, input ready);
  modport sink   (input valid, input left_pin, input right_pin, output ready);
endinterface

`default_nettype wire

// ===== sv/mwbd_out_if.sv =====
// Result channel: valid/ready handshake carrying the debounced button code.
// No dependencies.
`default_nettype none

interface mwbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] pressed;

  modport source (output valid, output pressed, input ready);
  modport sink   (input valid, input pressed, output ready);
endinterface

`default_nettype wire

// ===== sv/mwbd_cell.sv =====
// One window cell: holds a single sample class and hands it to the next cell
// on every accepted beat. Depends on mwbd_pkg.
`default_nettype none

module mwbd_cell
  import mwbd_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  shift,
  input  cls_t cls_in,
  output cls_t cls_out
);

  cls_t cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= CLS_NONE;
    end else if (shift) begin
      cls_r <= cls_in;
    end
  end

  assign cls_out = cls_r;

endmodule

`default_nettype wire

// ===== sv/mwbd_tally.sv =====
// Running per-class counts, majority pick and press latch with hysteresis.
// Depends on mwbd_pkg.
`default_nettype none

module mwbd_tally
  import mwbd_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  step_t step_i,
  input  thr_t  thr_i,
  output cls_t  latched
);

  cnt_t cnt_r   [4];
  cnt_t cnt_nxt [4];
  cls_t latched_r;
  cls_t latched_nxt;
  cls_t pick;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cnt_nxt[k] = cnt_r[k]
                 - CNT_W'(step_i.cls_old == cls_t'(2'(k)))
                 + CNT_W'(step_i.cls_new == cls_t'(2'(k)));
    end

    pick = (cnt_nxt[CLS_NONE] > cnt_nxt[CLS_CENTER]) ? CLS_NONE : CLS_CENTER;
    if (cnt_nxt[CLS_LEFT] > cnt_nxt[pick]) begin
      pick = CLS_LEFT;
    end
    if (cnt_nxt[CLS_RIGHT] > cnt_nxt[pick]) begin
      pick = CLS_RIGHT;
    end

    latched_nxt = latched_r;
    if (latched_r == CLS_NONE && pick != CLS_NONE) begin
      if (THR_W'(cnt_nxt[pick]) > thr_i.press_thr) begin
        latched_nxt = pick;
      end
    end else if (latched_r == pick) begin
      if (THR_W'(cnt_nxt[pick]) < thr_i.rel_thr) begin
        latched_nxt = CLS_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[CLS_NONE]   <= CNT_W'(WINDOW);
      cnt_r[CLS_CENTER] <= '0;
      cnt_r[CLS_LEFT]   <= '0;
      cnt_r[CLS_RIGHT]  <= '0;
      latched_r         <= CLS_NONE;
    end else if (step_i.step) begin
      cnt_r     <= cnt_nxt;
      latched_r <= latched_nxt;
    end
  end

  assign latched = latched_r;

endmodule

`default_nettype wire

// ===== sv/majority_window_button_debouncer.sv =====
// Top level of the majority window button debouncer: window cell chain,
// count/latch unit, configuration registers and result register.
// Depends on mwbd_pkg, mwbd_in_if, mwbd_out_if, mwbd_cell and mwbd_tally.
//
// Usage: each input beat carries left_pin and right_pin for one tick. The pair
// is classified (both high center, left only left, right only right, else
// none) and shifted into a chain of WINDOW cells; the class that falls off the
// end leaves the running counts. Each input beat yields exactly one result
// beat with pressed, the latched button after that tick (0 none, 1 center,
// 2 left, 3 right).
// Result: registered, valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while results are taken; the count update, majority pick and latch
// decision all complete in the cycle of acceptance.
// Stall: the result register holds its beat while out_ch.ready is low, and
// in_ch.ready drops only while that register is full and not being taken.
// Reset (rst_n low, synchronous): window all none, none count WINDOW, latch
// none, press threshold 70, release threshold 30, no result pending.
// Configuration: cfg_we with cfg_index 0 writes the press threshold, index 1
// the release threshold; other indexes are ignored. Write only while idle.
`default_nettype none

module majority_window_button_debouncer
  import mwbd_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  mwbd_in_if.sink               in_ch,
  mwbd_out_if.source            out_ch,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  logic             in_acc;
  logic             out_valid_r;
  logic [THR_W-1:0] press_thr_r;
  logic [THR_W-1:0] rel_thr_r;
  cls_t             cls_new;
  cls_t             chain [WINDOW];
  step_t            step;
  thr_t             thr;
  cls_t             latched;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cls_new     = classify(in_ch.left_pin, in_ch.right_pin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_thr_r <= PRESS_THR_RST;
      rel_thr_r   <= RELEASE_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRESS_THR:   press_thr_r <= cfg_data[THR_W-1:0];
        REG_RELEASE_THR: rel_thr_r   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      mwbd_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (in_acc),
        .cls_in  (cls_new),
        .cls_out (chain[i])
      );
    end else begin : g_body
      mwbd_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (in_acc),
        .cls_in  (chain[i-1]),
        .cls_out (chain[i])
      );
    end
  end

  assign step.step    = in_acc;
  assign step.cls_new = cls_new;
  assign step.cls_old = chain[WINDOW-1];
  assign thr.press_thr = press_thr_r;
  assign thr.rel_thr   = rel_thr_r;

  mwbd_tally u_tally (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .thr_i   (thr),
    .latched (latched)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pressed = latched;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_ch.valid)
    else $error("accepted beat produced no result");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(in_acc)) |-> $stable(out_ch.pressed))
    else $error("pressed changed without an input beat");

  a_via_none: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(out_ch.pressed) != CLS_NONE
      && out_ch.pressed != $past(out_ch.pressed)) |-> out_ch.pressed == CLS_NONE)
    else $error("press moved between buttons without release");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for majority_window_button_debouncer: drives pin beats, keeps its own
// sliding-window majority/latch predictor and checks every result beat against it.
// Depends on mwbd_pkg, mwbd_in_if, mwbd_out_if and the debouncer RTL.

module tb;
  import mwbd_pkg::*;

  localparam int PERIOD     = 4;
  localparam int HANG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  typedef enum int {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mwbd_in_if  in_ch ();
  mwbd_out_if out_ch ();

  majority_window_button_debouncer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  cls_t             win_hist [WINDOW];
  int unsigned      cls_count [4];
  cls_t             latch_cls;
  int unsigned      win_pos;
  logic [THR_W-1:0] press_lvl;
  logic [THR_W-1:0] release_lvl;
  cls_t             pressed_q [$];

  int       errors = 0;
  int       hang_cnt = 0;
  int       burst_left = 0;
  bit       tx_idle = 1'b0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_tick = 0;

  function automatic void debounce_reset();
    for (int i = 0; i < WINDOW; i++) begin
      win_hist[i] = CLS_NONE;
    end
    cls_count[CLS_NONE]   = WINDOW;
    cls_count[CLS_CENTER] = 0;
    cls_count[CLS_LEFT]   = 0;
    cls_count[CLS_RIGHT]  = 0;
    latch_cls   = CLS_NONE;
    win_pos     = 0;
    press_lvl   = THR_W'(70);
    release_lvl = THR_W'(30);
  endfunction

  function automatic cls_t debounce_step(logic l, logic r);
    cls_t c;
    cls_t gone;
    cls_t pick;
    case ({l, r})
      2'b11: c = CLS_CENTER;
      2'b10: c = CLS_LEFT;
      2'b01: c = CLS_RIGHT;
      default: c = CLS_NONE;
    endcase
    gone = win_hist[win_pos];
    cls_count[gone] = cls_count[gone] - 1;
    cls_count[c] = cls_count[c] + 1;
    win_hist[win_pos] = c;
    win_pos = (win_pos == WINDOW - 1) ? 0 : win_pos + 1;

    pick = (cls_count[CLS_NONE] > cls_count[CLS_CENTER]) ? CLS_NONE : CLS_CENTER;
    if (cls_count[CLS_LEFT] > cls_count[pick]) pick = CLS_LEFT;
    if (cls_count[CLS_RIGHT] > cls_count[pick]) pick = CLS_RIGHT;

    if (latch_cls == CLS_NONE && pick != CLS_NONE) begin
      if (cls_count[pick] > press_lvl) latch_cls = pick;
    end else if (latch_cls == pick) begin
      if (cls_count[pick] < release_lvl) latch_cls = CLS_NONE;
    end
    return latch_cls;
  endfunction

  always @(posedge clk) begin : result_check
    cls_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pressed_q.size() == 0) begin
          $error("pressed: expected nothing, actual %0d", out_ch.pressed);
          errors++;
        end else begin
          want = pressed_q.pop_front();
          if (out_ch.pressed !== want) begin
            $error("pressed: expected %0d, actual %0d", want, out_ch.pressed);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pressed_q.push_back(debounce_step(in_ch.left_pin, in_ch.right_pin));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PRESS_THR:   press_lvl = cfg_data;
          REG_RELEASE_THR: release_lvl = cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      hang_cnt <= 0;
    end else if (hang_cnt >= HANG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  always @(negedge clk) begin
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_ch.ready = 1'b1;
      RX_RANDOM: out_ch.ready = ($urandom_range(0, 99) >= 35);
      default:   out_ch.ready = ((rx_tick % 11) > 3);
    endcase
  end

  task automatic send_beat(logic l, logic r);
    int gap;
    if (tx_idle && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (tx_idle) burst_left--;
    in_ch.valid     = 1'b1;
    in_ch.left_pin  = l;
    in_ch.right_pin = r;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pressed_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_run(cls_t c, int len, int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_beat(1'($urandom), 1'($urandom));
      end else begin
        case (c)
          CLS_CENTER: send_beat(1'b1, 1'b1);
          CLS_LEFT:   send_beat(1'b1, 1'b0);
          CLS_RIGHT:  send_beat(1'b0, 1'b1);
          default:    send_beat(1'b0, 1'b0);
        endcase
      end
    end
  endtask

  // send runs of random classes, 5 to 130 beats each (cut to the budget), with up to 25 percent noise
  task automatic press_runs(int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      len = $urandom_range(5, 130);
      if (len > budget - sent) len = budget - sent;
      send_run(cls_t'($urandom_range(0, 3)), len, $urandom_range(0, 25));
      sent += len;
    end
  endtask

  task automatic test_pin_corners();
    rx_mode = RX_RANDOM;
    tx_idle = 1'b1;
    send_run(CLS_NONE, 3, 0);
    send_run(CLS_CENTER, 3, 0);
    send_run(CLS_LEFT, 3, 0);
    send_run(CLS_RIGHT, 3, 0);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    send_run(CLS_CENTER, 4, 0);
    send_run(CLS_NONE, 4, 0);
    drain_results();
  endtask

  task automatic test_default_thresholds();
    rx_mode = RX_OPEN;
    tx_idle = 1'b0;
    press_runs(100);
    drain_results();
  endtask

  task automatic test_low_extremes();
    write_reg(REG_PRESS_THR, '0);
    write_reg(REG_RELEASE_THR, '0);
    rx_mode = RX_RANDOM;
    tx_idle = 1'b1;
    press_runs(45);
    drain_results();
    press_runs(45);
    drain_results();
  endtask

  task automatic test_high_extremes();
    write_reg(REG_PRESS_THR, '1);
    write_reg(REG_RELEASE_THR, '1);
    rx_mode = RX_BURSTY;
    tx_idle = 1'b1;
    press_runs(80);
    drain_results();
  endtask

  task automatic test_inverted_thresholds();
    write_reg(REG_PRESS_THR, CFG_DATA_W'(20));
    write_reg(REG_RELEASE_THR, CFG_DATA_W'(60));
    rx_mode = RX_RANDOM;
    tx_idle = 1'b0;
    press_runs(90);
    drain_results();
  endtask

  task automatic test_random_thresholds();
    for (int k = 0; k < 3; k++) begin
      write_reg(REG_PRESS_THR, CFG_DATA_W'($urandom_range(0, 110)));
      write_reg(REG_RELEASE_THR, CFG_DATA_W'($urandom_range(0, 110)));
      write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      tx_idle = 1'($urandom);
      press_runs(40);
    end
    drain_results();
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.left_pin  = 1'b0;
    in_ch.right_pin = 1'b0;
    out_ch.ready    = 1'b0;
    debounce_reset();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_pin_corners();
    test_default_thresholds();
    test_low_extremes();
    test_high_extremes();
    test_inverted_thresholds();
    test_random_thresholds();

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mwbd_pkg.sv
sv/mwbd_in_if.sv
sv/mwbd_out_if.sv
sv/mwbd_cell.sv
sv/mwbd_tally.sv
sv/majority_window_button_debouncer.sv
test/tb.sv
